FILE: rtl/bdq_pkg.sv
// Shared constants, codes and types of the bounded deque with search.
package bdq_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int ENTRY_W   = 6;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;

  // Cell load selection
  localparam logic [1:0] SEL_HOLD = 2'd0;
  localparam logic [1:0] SEL_PREV = 2'd1;
  localparam logic [1:0] SEL_NEXT = 2'd2;
  localparam logic [1:0] SEL_KEY  = 2'd3;

  typedef struct packed {
    logic       live;
    logic [1:0] sel;
  } cell_ctl_t;

endpackage

FILE: rtl/bdq_cell.sv
// One storage cell of the deque row: holds an entry, compares it, shifts it.
module bdq_cell (
  input  logic                        clk,
  input  bdq_pkg::cell_ctl_t          ctl,
  input  logic [bdq_pkg::DATA_W-1:0]  key_i,
  input  logic [bdq_pkg::DATA_W-1:0]  prev_i,
  input  logic [bdq_pkg::DATA_W-1:0]  next_i,
  output logic [bdq_pkg::DATA_W-1:0]  data_o,
  output logic                        match_o
);

  logic [bdq_pkg::DATA_W-1:0] data_r;
  logic [bdq_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    unique case (ctl.sel)
      bdq_pkg::SEL_HOLD: data_nxt = data_r;
      bdq_pkg::SEL_PREV: data_nxt = prev_i;
      bdq_pkg::SEL_NEXT: data_nxt = next_i;
      bdq_pkg::SEL_KEY:  data_nxt = key_i;
      default:           data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign match_o = ctl.live && (data_r == key_i);

endmodule

FILE: rtl/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: request handling and the row of cells.
//
// Ordered store of up to CAPACITY signed 32-bit entries, kept front first in a row
// of cells. A request passes two steps: the item is registered, then all cells
// compare against the key at once and the row shifts by one place (or a single cell
// loads, or none moves) while the result goes to the output register; this waits
// only while the output register still holds an untaken result. The next request
// is taken in the cycle after that, so none is taken before the last is through.
// Entries are not cleared at reset, only the count, so the block is ready at once.
module bounded_deque_with_search_top #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: key_value[31:0]
  input  logic [bdq_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: req_type[2:0]
  input  logic [bdq_pkg::REQ_W-1:0]       in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: removed_value[31:0], entries_after[37:32], zero pad[39:38]
  output logic [bdq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: status[2:0]
  output logic [bdq_pkg::STATUS_W-1:0]    out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int DW = bdq_pkg::DATA_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                        state_r, state_nxt;
  logic [bdq_pkg::REQ_W-1:0]   req_r;
  logic [DW-1:0]               key_r;
  logic [CW-1:0]               count_r, count_nxt;

  logic                        out_valid_r;
  logic [DW-1:0]               out_removed_r, removed_nxt;
  logic [bdq_pkg::ENTRY_W-1:0] out_entries_r;
  logic [bdq_pkg::STATUS_W-1:0] out_status_r, status_nxt;

  logic                        advance;
  logic                        in_fire;

  logic [DW-1:0]               cell_data [CAPACITY];
  logic [CAPACITY-1:0]         match;
  logic [CAPACITY-1:0]         low_mask;
  logic [CAPACITY-1:0]         first_hit;
  logic [CAPACITY-1:0]         shift_mask;
  logic                        any_hit;
  logic                        is_full;
  logic                        is_empty;
  logic [IW-1:0]               back_idx;

  // Per-request row operation
  logic                        do_push_front;
  logic                        do_push_back;
  logic                        do_pop_front;
  logic                        do_delete;

  bdq_pkg::cell_ctl_t          cell_ctl [CAPACITY];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign advance   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign back_idx = IW'(count_r - CW'(1));

  // Lowest match marks the entry to delete; it and all above close the gap.
  assign low_mask   = match ^ (match - {{(CAPACITY-1){1'b0}}, 1'b1});
  assign first_hit  = low_mask & match;
  assign shift_mask = ~low_mask | first_hit;
  assign any_hit    = |match;

  always_comb begin
    status_nxt    = bdq_pkg::ST_DONE;
    removed_nxt   = '0;
    count_nxt     = count_r;
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    do_delete     = 1'b0;
    unique case (req_r)
      bdq_pkg::REQ_PUSH_FRONT,
      bdq_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = bdq_pkg::ST_FULL;
        end else begin
          count_nxt     = count_r + CW'(1);
          do_push_front = (req_r == bdq_pkg::REQ_PUSH_FRONT);
          do_push_back  = (req_r == bdq_pkg::REQ_PUSH_BACK);
        end
      end
      bdq_pkg::REQ_POP_FRONT,
      bdq_pkg::REQ_POP_BACK: begin
        if (is_empty) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          count_nxt    = count_r - CW'(1);
          do_pop_front = (req_r == bdq_pkg::REQ_POP_FRONT);
          removed_nxt  = (req_r == bdq_pkg::REQ_POP_FRONT) ? cell_data[0]
                                                           : cell_data[back_idx];
        end
      end
      bdq_pkg::REQ_DELETE,
      bdq_pkg::REQ_SEARCH: begin
        if (is_empty) begin
          status_nxt = bdq_pkg::ST_EMPTY;
        end else if (!any_hit) begin
          status_nxt = bdq_pkg::ST_NOT_FOUND;
        end else if (req_r == bdq_pkg::REQ_SEARCH) begin
          status_nxt = bdq_pkg::ST_FOUND;
        end else begin
          removed_nxt = key_r;
          count_nxt   = count_r - CW'(1);
          do_delete   = 1'b1;
        end
      end
      default: begin
        status_nxt = bdq_pkg::ST_DONE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DW-1:0] prev_w;
      logic [DW-1:0] next_w;

      if (gi == 0) begin : g_first
        assign prev_w = key_r;
      end else begin : g_mid_prev
        assign prev_w = cell_data[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign next_w = key_r;
      end else begin : g_mid_next
        assign next_w = cell_data[gi+1];
      end

      always_comb begin
        cell_ctl[gi].live = (CW'(gi) < count_r);
        cell_ctl[gi].sel  = bdq_pkg::SEL_HOLD;
        if (advance) begin
          priority if (do_push_front) begin
            cell_ctl[gi].sel = bdq_pkg::SEL_PREV;
          end else if (do_push_back && (count_r == CW'(gi))) begin
            cell_ctl[gi].sel = bdq_pkg::SEL_KEY;
          end else if (do_pop_front || (do_delete && shift_mask[gi])) begin
            cell_ctl[gi].sel = bdq_pkg::SEL_NEXT;
          end else begin
            cell_ctl[gi].sel = bdq_pkg::SEL_HOLD;
          end
        end
      end

      bdq_cell u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[gi]),
        .key_i   (key_r),
        .prev_i  (prev_w),
        .next_i  (next_w),
        .data_o  (cell_data[gi]),
        .match_o (match[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: if (advance) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: request capture and result hold
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_tuser;
      key_r <= in_tdata[DW-1:0];
    end
    if (advance) begin
      out_status_r  <= status_nxt;
      out_removed_r <= removed_nxt;
      out_entries_r <= bdq_pkg::ENTRY_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(bdq_pkg::OUT_DATA_W - DW - bdq_pkg::ENTRY_W){1'b0}},
                       out_entries_r, out_removed_r};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_result_from_exec : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == ST_EXEC))
    else $error("result raised without a request in execution");

  a_accept_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execution");

  a_count_only_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(advance)) |-> $stable(count_r))
    else $error("entry count changed without a request completing");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the bounded deque with search: random and directed requests.
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 450;
  localparam int QUIET_ITEMS    = 60;
  localparam int PHASE_ITEMS    = 40;
  localparam int HOLD_AT_ITEM   = 150;
  localparam int HOLD_CYCLES    = 160;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 100000;

  // Request codes the block treats as no operation
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_CHURN} traffic_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   removed;
    logic [ENTRY_W-1:0]  entries;
  } deque_result_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] stored[$];        // front entry at index 0
    deque_result_t     awaited_results[$];
    int unsigned       errors;

    function void note_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] key);
      deque_result_t r;
      int hit_at;
      r.status  = ST_DONE;
      r.removed = '0;
      hit_at    = -1;
      case (req)
        REQ_PUSH_FRONT: begin
          if (stored.size() >= DEPTH) r.status = ST_FULL;
          else stored.push_front(key);
        end
        REQ_PUSH_BACK: begin
          if (stored.size() >= DEPTH) r.status = ST_FULL;
          else stored.push_back(key);
        end
        REQ_POP_FRONT: begin
          if (stored.size() == 0) r.status = ST_EMPTY;
          else r.removed = stored.pop_front();
        end
        REQ_POP_BACK: begin
          if (stored.size() == 0) r.status = ST_EMPTY;
          else r.removed = stored.pop_back();
        end
        REQ_DELETE, REQ_SEARCH: begin
          if (stored.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // first match from the front wins
            foreach (stored[i]) if (hit_at < 0 && stored[i] == key) hit_at = i;
            if (hit_at < 0) begin
              r.status = ST_NOT_FOUND;
            end else if (req == REQ_SEARCH) begin
              r.status = ST_FOUND;
            end else begin
              r.removed = key;
              stored.delete(hit_at);
            end
          end
        end
        default: ;
      endcase
      r.entries = ENTRY_W'(stored.size());
      awaited_results.push_back(r);
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] removed,
                                 logic [ENTRY_W-1:0] entries);
      deque_result_t e;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual status %0d removed %h count %0d",
                 $time, status, removed, entries);
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (removed !== e.removed) begin
        $display("%0t: removed value expected %h actual %h", $time, e.removed, removed);
        errors++;
      end
      if (entries !== e.entries) begin
        $display("%0t: entry count expected %0d actual %0d", $time, e.entries, entries);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  deque_scoreboard sb = new();
  bit              send_gaps = 1'b1;
  bit              recv_stalls = 1'b1;
  bit              hold_out = 1'b0;
  bit              hold_done = 1'b0;
  int unsigned     cycle_count = 0;
  logic [DATA_W-1:0] key_pool[6];

  bounded_deque_with_search_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check results before noting new requests taken at the same edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_response(out_tuser, out_tdata[DATA_W-1:0], out_tdata[DATA_W+ENTRY_W-1:DATA_W]);
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata);
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_out && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!recv_stalls || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] key);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    // favour stored values so that searches and deletes hit
    if (roll < 45 && sb.stored.size() != 0)
      return sb.stored[$urandom_range(0, sb.stored.size() - 1)];
    if (roll < 80)
      return key_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(traffic_mode_t mode);
    int roll;
    logic [REQ_W-1:0] grow, shrink;
    roll   = $urandom_range(0, 99);
    grow   = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    shrink = REQ_POP_FRONT + REQ_W'($urandom_range(0, 2));
    case (mode)
      MODE_FILL:  return (roll < 85) ? grow : REQ_SEARCH;
      MODE_DRAIN: return (roll < 85) ? shrink : REQ_SEARCH;
      MODE_CHURN: return (roll < 50) ? grow : ((roll < 75) ? REQ_DELETE : REQ_SEARCH);
      default:    return REQ_PUSH_FRONT + REQ_W'($urandom_range(0, 5));
    endcase
  endfunction

  initial begin
    int made;
    traffic_mode_t mode;
    logic [REQ_W-1:0] req;
    foreach (key_pool[i]) key_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, spare codes, extremes, duplicates, last entry
    send_request(REQ_POP_FRONT,  32'h0);
    send_request(REQ_POP_BACK,   32'hFFFF_FFFF);
    send_request(REQ_DELETE,     32'h1234_5678);
    send_request(REQ_SEARCH,     32'h8000_0000);
    send_request(REQ_SPARE_A,    32'hDEAD_BEEF);
    send_request(REQ_SPARE_B,    32'h0);
    send_request(REQ_PUSH_BACK,  32'h7FFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_PUSH_BACK,  32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK,  32'h7FFF_FFFF);
    send_request(REQ_SEARCH,     32'h7FFF_FFFF);
    send_request(REQ_SEARCH,     32'h5555_5555);
    send_request(REQ_DELETE,     32'hAAAA_AAAA);
    send_request(REQ_DELETE,     32'h7FFF_FFFF);
    send_request(REQ_SEARCH,     32'h7FFF_FFFF);
    send_request(REQ_POP_FRONT,  32'h0);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_POP_FRONT,  32'h0);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_POP_BACK,   32'h0);
    send_request(REQ_PUSH_FRONT, 32'h5A5A_5A5A);
    send_request(REQ_DELETE,     32'h5A5A_5A5A);
    send_request(REQ_SEARCH,     32'h5A5A_5A5A);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = traffic_mode_t'((made / PHASE_ITEMS) % 4);
      send_gaps = ((made / PHASE_ITEMS) % 3) != 2;
      if (made >= RANDOM_ITEMS - QUIET_ITEMS) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      if (made == HOLD_AT_ITEM) hold_out = 1'b1;
      if ($urandom_range(0, 99) < 2) begin
        // spare codes do nothing; leave them out of the count
        send_request($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B, $urandom);
      end else begin
        req = pick_request(mode);
        send_request(req, pick_key());
        made++;
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
